>>> src/assert_macros.svh
// Assertion macros used by the checker file bir_checker.sv.
// Needs a clock and an active-low reset in the calling scope's arguments.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define BIR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition at one edge implies consequence at the next edge.
`define BIR_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/bir_pkg.sv
// Package of the bilinear image remap block: widths, codes and types.
// No dependencies.
`default_nettype none
package bir_pkg;
  localparam int CoordW    = 20;
  localparam int FracW     = 8;
  localparam int IntW      = CoordW - FracW;
  localparam int DimW      = 11;
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int AddrW     = 20;
  localparam int Depth     = 1 << AddrW;
  localparam int ChW       = 8;
  localparam int NumCh     = 3;
  localparam int PixW      = ChW * NumCh;
  localparam int One       = 1 << FracW;
  localparam int WgtW      = 2 * FracW + 1;
  localparam int ProdW     = ChW + WgtW;
  localparam int AccW      = ProdW + 2;
  localparam int CntW      = 2;
  localparam int CfgIdxW   = 2;
  localparam int NumNb     = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth, CfgHeight, CfgMode, CfgChans
  } cfg_reg_e;

  typedef enum logic {
    ActLoad  = 1'b0,
    ActRemap = 1'b1
  } action_e;

  typedef enum logic {
    ModeNearest  = 1'b0,
    ModeBilinear = 1'b1
  } mode_e;

  typedef struct packed {
    logic            in_img;
    logic [CntW-1:0] nch;
  } blend_ctrl_t;
endpackage
`default_nettype wire

>>> src/bir_intf.sv
// Handshake channels of the bilinear image remap block.
// Depends on bir_pkg.
`default_nettype none
interface bir_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic        [bir_pkg::AddrW-1:0]    pixel_addr;
  logic        [bir_pkg::ChW-1:0]      in_ch0;
  logic        [bir_pkg::ChW-1:0]      in_ch1;
  logic        [bir_pkg::ChW-1:0]      in_ch2;
  logic signed [bir_pkg::CoordW-1:0]   src_x;
  logic signed [bir_pkg::CoordW-1:0]   src_y;
  modport source (output valid, action, pixel_addr, in_ch0, in_ch1, in_ch2, src_x, src_y,
                  input ready);
  modport sink (input valid, action, pixel_addr, in_ch0, in_ch1, in_ch2, src_x, src_y,
                output ready);
endinterface

interface bir_out_if;
  logic                     valid;
  logic                     ready;
  logic [bir_pkg::ChW-1:0]  out_ch0;
  logic [bir_pkg::ChW-1:0]  out_ch1;
  logic [bir_pkg::ChW-1:0]  out_ch2;
  logic                     inside_res;
  modport source (output valid, out_ch0, out_ch1, out_ch2, inside_res, input ready);
  modport sink (input valid, out_ch0, out_ch1, out_ch2, inside_res, output ready);
endinterface

interface bir_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bir_pkg::CfgIdxW-1:0]  index;
  logic [bir_pkg::DimW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/bir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bir_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end
endmodule
`default_nettype wire

>>> src/bir_blend.sv
// Weighting and summing stages of the remap sampler, with the output register.
// Depends on bir_pkg and bir_out_if.
`default_nettype none
module bir_blend (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire bir_pkg::blend_ctrl_t        ctrl_i,
  input  wire logic [bir_pkg::PixW-1:0]    pix_i [bir_pkg::NumNb],
  input  wire logic [bir_pkg::WgtW-1:0]    wgt_i [bir_pkg::NumNb],
  bir_out_if.source                        out_o
);
  logic                       v5_q, vo_q;
  logic                       en5, en6;
  bir_pkg::blend_ctrl_t       ctrl5_q;
  logic [bir_pkg::ProdW-1:0]  prod_d [bir_pkg::NumCh][bir_pkg::NumNb];
  logic [bir_pkg::ProdW-1:0]  prod_q [bir_pkg::NumCh][bir_pkg::NumNb];
  logic [bir_pkg::AccW-1:0]   acc [bir_pkg::NumCh];
  logic [bir_pkg::ChW-1:0]    res_d [bir_pkg::NumCh];
  logic [bir_pkg::ChW-1:0]    res_q [bir_pkg::NumCh];
  logic                       inside_q;

  assign en6     = !vo_q || out_o.ready;
  assign en5     = !v5_q || en6;
  assign ready_o = en5;

  always_comb begin
    for (int c = 0; c < bir_pkg::NumCh; c++) begin
      for (int k = 0; k < bir_pkg::NumNb; k++) begin
        prod_d[c][k] = bir_pkg::ProdW'(pix_i[k][c*bir_pkg::ChW +: bir_pkg::ChW])
                     * bir_pkg::ProdW'(wgt_i[k]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < bir_pkg::NumCh; c++) begin
      acc[c] = bir_pkg::AccW'(prod_q[c][0]) + bir_pkg::AccW'(prod_q[c][1])
             + bir_pkg::AccW'(prod_q[c][2]) + bir_pkg::AccW'(prod_q[c][3]);
      res_d[c] = acc[c][2*bir_pkg::FracW +: bir_pkg::ChW];
      if (!ctrl5_q.in_img || (ctrl5_q.nch <= bir_pkg::CntW'(c))) begin
        res_d[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) vo_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      prod_q  <= prod_d;
      ctrl5_q <= ctrl_i;
    end
    if (en6) begin
      res_q    <= res_d;
      inside_q <= ctrl5_q.in_img;
    end
  end

  assign out_o.valid      = vo_q;
  assign out_o.out_ch0    = res_q[0];
  assign out_o.out_ch1    = res_q[1];
  assign out_o.out_ch2    = res_q[2];
  assign out_o.inside_res = inside_q;
endmodule
`default_nettype wire

>>> src/bilinear_image_remap.sv
// Top level of the bilinear image remap block: image store and sampler pipeline.
// Depends on bir_pkg, bir_intf, bir_ram and bir_blend.
//
// Takes one word per clock unless the output stalls, and carries it through six
// register stages, the first loaded at the accepting edge, to a remap result at
// the output; loads travel the same pipeline and write the store when they
// reach the read stage, so every remap sees all earlier loads. The store is held
// in four copies, one per bilinear neighbour, each giving one read per cycle;
// that and the row multipliers of the address stage set the sustained rate of
// one item per clock. Each stage holds on its own, so gaps close up under stall.
`default_nettype none
module bilinear_image_remap (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bir_in_if.sink    in_i,
  bir_out_if.source out_o,
  bir_cfg_if.sink   cfg_i
);
  localparam int RowProdW = bir_pkg::RowW + bir_pkg::DimW;
  localparam int WProdW   = 2 * bir_pkg::FracW + 2;

  logic [bir_pkg::DimW-1:0]  width_q, height_q, w_eff, h_eff;
  logic                      mode_q;
  logic [bir_pkg::CntW-1:0]  chans_q;

  logic en1, en2, en3, en4, blend_ready;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1
  logic                       act1_q;
  logic [bir_pkg::AddrW-1:0]  addr1_q;
  logic [bir_pkg::PixW-1:0]   pix1_q;
  logic [bir_pkg::CoordW-1:0] cx1_q, cy1_q;
  // stage 2
  logic [bir_pkg::IntW-1:0]   xint, yint;
  logic [bir_pkg::ColW-1:0]   xi_d, x1_d;
  logic [bir_pkg::RowW-1:0]   yi_d, y1_d;
  logic [bir_pkg::DimW-1:0]   xn, yn;
  logic                       inside_d;
  logic                       act2_q, inside2_q;
  logic [bir_pkg::AddrW-1:0]  addr2_q;
  logic [bir_pkg::PixW-1:0]   pix2_q;
  logic [bir_pkg::ColW-1:0]   xi2_q, x12_q;
  logic [bir_pkg::RowW-1:0]   yi2_q, y12_q;
  logic [bir_pkg::FracW-1:0]  fx2_q, fy2_q;
  // stage 3
  logic [RowProdW-1:0]        row0, row1;
  logic [bir_pkg::FracW:0]    ifx, ify;
  logic [WProdW-1:0]          wfull [bir_pkg::NumNb];
  logic [bir_pkg::AddrW-1:0]  a_d [bir_pkg::NumNb];
  logic [bir_pkg::WgtW-1:0]   wgt_d [bir_pkg::NumNb];
  logic                       act3_q;
  logic [bir_pkg::AddrW-1:0]  a3_q [bir_pkg::NumNb];
  logic [bir_pkg::WgtW-1:0]   wgt3_q [bir_pkg::NumNb];
  logic [bir_pkg::PixW-1:0]   pix3_q;
  bir_pkg::blend_ctrl_t       ctrl3_d, ctrl3_q;
  // stage 4
  logic [bir_pkg::WgtW-1:0]   wgt4_q [bir_pkg::NumNb];
  bir_pkg::blend_ctrl_t       ctrl4_q;
  logic [bir_pkg::PixW-1:0]   rdata [bir_pkg::NumNb];
  logic                       store_we;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bir_pkg::DimW'(bir_pkg::MaxWidth);
      height_q <= bir_pkg::DimW'(bir_pkg::MaxHeight);
      mode_q   <= bir_pkg::ModeBilinear;
      chans_q  <= bir_pkg::CntW'(1);
    end else if (cfg_i.valid) begin
      case (bir_pkg::cfg_reg_e'(cfg_i.index))
        bir_pkg::CfgWidth:  width_q  <= cfg_i.data;
        bir_pkg::CfgHeight: height_q <= cfg_i.data;
        bir_pkg::CfgMode:   mode_q   <= cfg_i.data[0];
        bir_pkg::CfgChans:  chans_q  <= cfg_i.data[bir_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q > bir_pkg::DimW'(bir_pkg::MaxWidth))
               ? bir_pkg::DimW'(bir_pkg::MaxWidth) : width_q;
  assign h_eff = (height_q > bir_pkg::DimW'(bir_pkg::MaxHeight))
               ? bir_pkg::DimW'(bir_pkg::MaxHeight) : height_q;

  assign en4 = !v4_q || blend_ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  // integer and fractional parts, inside test, edge clamp
  always_comb begin
    xint     = cx1_q[bir_pkg::CoordW-1:bir_pkg::FracW];
    yint     = cy1_q[bir_pkg::CoordW-1:bir_pkg::FracW];
    inside_d = !cx1_q[bir_pkg::CoordW-1] && !cy1_q[bir_pkg::CoordW-1]
             && (xint < bir_pkg::IntW'(w_eff)) && (yint < bir_pkg::IntW'(h_eff));
    xi_d     = xint[bir_pkg::ColW-1:0];
    yi_d     = yint[bir_pkg::RowW-1:0];
    xn       = bir_pkg::DimW'(xi_d) + bir_pkg::DimW'(1);
    yn       = bir_pkg::DimW'(yi_d) + bir_pkg::DimW'(1);
    x1_d     = (xn == w_eff) ? xi_d : xn[bir_pkg::ColW-1:0];
    y1_d     = (yn == h_eff) ? yi_d : yn[bir_pkg::RowW-1:0];
  end

  // neighbour addresses and weights
  always_comb begin
    row0 = RowProdW'(yi2_q) * RowProdW'(w_eff);
    row1 = RowProdW'(y12_q) * RowProdW'(w_eff);
    a_d[0] = act2_q ? bir_pkg::AddrW'(row0 + RowProdW'(xi2_q)) : addr2_q;
    a_d[1] = bir_pkg::AddrW'(row0 + RowProdW'(x12_q));
    a_d[2] = bir_pkg::AddrW'(row1 + RowProdW'(xi2_q));
    a_d[3] = bir_pkg::AddrW'(row1 + RowProdW'(x12_q));
    ifx = (bir_pkg::FracW+1)'(bir_pkg::One) - (bir_pkg::FracW+1)'(fx2_q);
    ify = (bir_pkg::FracW+1)'(bir_pkg::One) - (bir_pkg::FracW+1)'(fy2_q);
    wfull[0] = WProdW'(ifx) * WProdW'(ify);
    wfull[1] = WProdW'(fx2_q) * WProdW'(ify);
    wfull[2] = WProdW'(ifx) * WProdW'(fy2_q);
    wfull[3] = WProdW'(fx2_q) * WProdW'(fy2_q);
    for (int k = 0; k < bir_pkg::NumNb; k++) begin
      wgt_d[k] = wfull[k][bir_pkg::WgtW-1:0];
    end
    if (mode_q == bir_pkg::ModeNearest) begin
      wgt_d[0] = bir_pkg::WgtW'(bir_pkg::One * bir_pkg::One);
      wgt_d[1] = '0;
      wgt_d[2] = '0;
      wgt_d[3] = '0;
      // read only the sampled pixel
      a_d[1]   = a_d[0];
      a_d[2]   = a_d[0];
      a_d[3]   = a_d[0];
    end
    ctrl3_d.in_img = inside2_q;
    ctrl3_d.nch    = (chans_q == '0) ? bir_pkg::CntW'(1) : chans_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q && (act3_q == bir_pkg::ActRemap);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      act1_q  <= in_i.action;
      addr1_q <= in_i.pixel_addr;
      pix1_q  <= {in_i.in_ch2, in_i.in_ch1, in_i.in_ch0};
      cx1_q   <= in_i.src_x;
      cy1_q   <= in_i.src_y;
    end
    if (en2) begin
      act2_q    <= act1_q;
      inside2_q <= inside_d;
      addr2_q   <= addr1_q;
      pix2_q    <= pix1_q;
      xi2_q     <= xi_d;
      x12_q     <= x1_d;
      yi2_q     <= yi_d;
      y12_q     <= y1_d;
      fx2_q     <= cx1_q[bir_pkg::FracW-1:0];
      fy2_q     <= cy1_q[bir_pkg::FracW-1:0];
    end
    if (en3) begin
      act3_q  <= act2_q;
      a3_q    <= a_d;
      wgt3_q  <= wgt_d;
      pix3_q  <= pix2_q;
      ctrl3_q <= ctrl3_d;
    end
    if (en4) begin
      wgt4_q  <= wgt3_q;
      ctrl4_q <= ctrl3_q;
    end
  end

  assign store_we = en4 && v3_q && (act3_q == bir_pkg::ActLoad);

  for (genvar k = 0; k < bir_pkg::NumNb; k++) begin : g_store
    bir_ram #(
      .Width(bir_pkg::PixW),
      .Depth(bir_pkg::Depth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (store_we),
      .waddr_i(a3_q[0]),
      .wdata_i(pix3_q),
      .re_i   (en4),
      .raddr_i(a3_q[k]),
      .rdata_o(rdata[k])
    );
  end

  bir_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v4_q),
    .ready_o(blend_ready),
    .ctrl_i (ctrl4_q),
    .pix_i  (rdata),
    .wgt_i  (wgt4_q),
    .out_o  (out_o)
  );
endmodule
`default_nettype wire

>>> src/bir_checker.sv
// Port-level checks of the bilinear image remap block, bound to its top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module bir_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_ch0,
  input wire logic [7:0] out_ch1,
  input wire logic [7:0] out_ch2,
  input wire logic       inside_res
);
  `BIR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `BIR_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid && !out_ready, $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2) && $stable(inside_res))
  `BIR_ASSERT(a_outside_zero, clk_i, rst_ni, (out_valid && !inside_res) |-> (out_ch0 == 8'd0 && out_ch1 == 8'd0 && out_ch2 == 8'd0))
  `BIR_ASSERT(a_ready_flow, clk_i, rst_ni, out_ready |-> in_ready)
endmodule

bind bilinear_image_remap bir_checker u_bir_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_ch0   (out_o.out_ch0),
  .out_ch1   (out_o.out_ch1),
  .out_ch2   (out_o.out_ch2),
  .inside_res(out_o.inside_res)
);
`default_nettype wire
